### design/reil_pkg.sv
package reil_pkg;

  // default table geometry
  localparam int unsigned MAX_RUNS_DEF  = 1024;
  localparam int unsigned END_WIDTH_DEF = 32;

  // command codes, code 3 is unused and acts as a no-op
  typedef enum logic [1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_APPEND = 2'd1,
    CMD_LOOKUP = 2'd2
  } reil_cmd_t;

  // result status codes
  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_RANGE = 2'd1,
    STAT_FULL  = 2'd2,
    STAT_ORDER = 2'd3
  } reil_status_t;

  // control states
  typedef enum logic {
    ST_IDLE   = 1'b0,
    ST_SEARCH = 1'b1
  } reil_state_t;

  // input beat
  typedef struct packed {
    reil_cmd_t   cmd;
    logic [31:0] run_end;
    logic        run_is_null;
    logic [31:0] logical_index;
  } reil_in_t;

  // result beat
  typedef struct packed {
    reil_status_t status;
    logic [9:0]   run_index;
    logic         run_null;
    logic [31:0]  total_length;
    logic [31:0]  null_sum;
    logic [10:0]  run_count;
  } reil_out_t;

  // search unit status towards the control
  typedef struct packed {
    logic done;
    logic run_null;
  } reil_srch_t;

endpackage

### design/reil_mem.sv
module reil_mem #(
  parameter int unsigned DEPTH = reil_pkg::MAX_RUNS_DEF,
  parameter int unsigned WIDTH = reil_pkg::END_WIDTH_DEF + 1
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] store_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      store_r[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= store_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

### design/reil_search.sv
module reil_search #(
  parameter int unsigned MAX_RUNS  = reil_pkg::MAX_RUNS_DEF,
  parameter int unsigned END_WIDTH = reil_pkg::END_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          go,
  input  logic [END_WIDTH-1:0]          key,
  input  logic [$clog2(MAX_RUNS+1)-1:0] count,
  input  logic [END_WIDTH:0]            rd_data,
  output logic                          rd_en,
  output logic [$clog2(MAX_RUNS)-1:0]   rd_addr,
  output reil_pkg::reil_srch_t          srch,
  output logic [$clog2(MAX_RUNS+1)-1:0] run_index
);
  import reil_pkg::*;

  localparam int unsigned AW = $clog2(MAX_RUNS);
  localparam int unsigned CW = $clog2(MAX_RUNS + 1);

  logic                 busy_r;
  logic [CW-1:0]        lo_r, lo_nxt;
  logic [CW-1:0]        hi_r, hi_nxt;
  logic [AW-1:0]        mid_r, mid_nxt;
  logic [END_WIDTH-1:0] key_r;
  logic                 cand_r, cand_nxt;
  logic [CW:0]          bound_sum;
  logic                 upd_hi;
  logic                 more;

  // probe compare on the word read for the previous midpoint
  assign upd_hi = busy_r && (rd_data[END_WIDTH-1:0] > key_r);

  // narrow the bounds, then pick the next midpoint
  always_comb begin
    if (go) begin
      lo_nxt = '0;
      hi_nxt = count;
    end else if (busy_r) begin
      if (upd_hi) begin
        lo_nxt = lo_r;
        hi_nxt = CW'(mid_r);
      end else begin
        lo_nxt = CW'(mid_r) + CW'(1);
        hi_nxt = hi_r;
      end
    end else begin
      lo_nxt = lo_r;
      hi_nxt = hi_r;
    end
    bound_sum = {1'b0, lo_nxt} + {1'b0, hi_nxt};
    mid_nxt   = AW'(bound_sum >> 1);
    more      = lo_nxt < hi_nxt;
    cand_nxt  = upd_hi ? rd_data[END_WIDTH] : cand_r;
  end

  // memory probe and status
  assign rd_en         = (go || busy_r) && more;
  assign rd_addr       = mid_nxt;
  assign srch.done     = busy_r && !more;
  assign srch.run_null = cand_nxt;
  assign run_index     = lo_nxt;

  // probe in flight
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= rd_en;
    end
  end

  // search bounds and key
  always_ff @(posedge clk) begin
    lo_r   <= lo_nxt;
    hi_r   <= hi_nxt;
    mid_r  <= mid_nxt;
    cand_r <= go ? 1'b0 : cand_nxt;
    if (go) begin
      key_r <= key;
    end
  end

endmodule

### design/run_end_index_lookup.sv
// Timing: clear, append, unused command and out-of-range lookup give their result
//   strobe in the cycle after the start beat; busy stays low and the next beat may follow.
// A lookup runs one memory probe per cycle, at most ceil(log2(run_count+1)) probes
//   (11 at 1024 runs); busy is high while the search runs, and the result strobe is
//   registered from the final probe compare and shows in the same cycle that busy falls.
// Reset (rst_n, synchronous, active low) empties the table; run memory is not cleared.
module run_end_index_lookup #(
  parameter int unsigned MAX_RUNS  = reil_pkg::MAX_RUNS_DEF,
  parameter int unsigned END_WIDTH = reil_pkg::END_WIDTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  reil_pkg::reil_in_t  in_item,
  output logic                busy,
  output logic                out_valid,
  output reil_pkg::reil_out_t out_item
);
  import reil_pkg::*;

  localparam int unsigned AW   = $clog2(MAX_RUNS);
  localparam int unsigned CW   = $clog2(MAX_RUNS + 1);
  localparam int unsigned CMPW = (END_WIDTH > 32) ? END_WIDTH : 32;

  reil_state_t          state_r, state_nxt;
  logic [CW-1:0]        cnt_r, cnt_nxt;
  logic [END_WIDTH-1:0] last_end_r, last_end_nxt;
  logic [END_WIDTH-1:0] null_total_r, null_total_nxt;
  logic                 out_valid_r, out_valid_nxt;
  reil_out_t            out_item_r, out_item_nxt;

  logic                 accept;
  logic [END_WIDTH-1:0] end_w;
  logic                 in_range;
  logic                 tbl_full;
  logic                 order_bad;
  logic                 wr_en;
  logic                 go;
  reil_status_t         status_w;
  logic [END_WIDTH:0]   rd_data;
  logic                 rd_en;
  logic [AW-1:0]        rd_addr;
  reil_srch_t           srch;
  logic [CW-1:0]        found_idx;

  // command decode
  assign accept    = start && !busy;
  assign end_w     = END_WIDTH'(in_item.run_end);
  assign in_range  = CMPW'(in_item.logical_index) < CMPW'(last_end_r);
  assign tbl_full  = cnt_r == CW'(MAX_RUNS);
  assign order_bad = end_w <= last_end_r;
  assign wr_en     = accept && (in_item.cmd == CMD_APPEND) && !tbl_full && !order_bad;
  assign go        = accept && (in_item.cmd == CMD_LOOKUP) && in_range;

  // run table: {null flag, run end} per entry
  reil_mem #(
    .DEPTH (MAX_RUNS),
    .WIDTH (END_WIDTH + 1)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (AW'(cnt_r)),
    .wr_data ({in_item.run_is_null, end_w}),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // upper-bound search
  reil_search #(
    .MAX_RUNS  (MAX_RUNS),
    .END_WIDTH (END_WIDTH)
  ) u_search (
    .clk       (clk),
    .rst_n     (rst_n),
    .go        (go),
    .key       (END_WIDTH'(in_item.logical_index)),
    .count     (cnt_r),
    .rd_data   (rd_data),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .srch      (srch),
    .run_index (found_idx)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (go) begin
          state_nxt = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        if (srch.done) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    case (state_r)
      ST_IDLE:   busy = 1'b0;
      ST_SEARCH: busy = 1'b1;
      default:   busy = 1'b0;
    endcase
  end

  // status of an immediate command
  always_comb begin
    case (in_item.cmd)
      CMD_APPEND: begin
        if (tbl_full) begin
          status_w = STAT_FULL;
        end else if (order_bad) begin
          status_w = STAT_ORDER;
        end else begin
          status_w = STAT_OK;
        end
      end
      CMD_LOOKUP: status_w = in_range ? STAT_OK : STAT_RANGE;
      default:    status_w = STAT_OK;
    endcase
  end

  // table summary update
  always_comb begin
    cnt_nxt        = cnt_r;
    last_end_nxt   = last_end_r;
    null_total_nxt = null_total_r;
    if (accept) begin
      case (in_item.cmd)
        CMD_CLEAR: begin
          cnt_nxt        = '0;
          last_end_nxt   = '0;
          null_total_nxt = '0;
        end
        CMD_APPEND: begin
          if (wr_en) begin
            cnt_nxt      = cnt_r + CW'(1);
            last_end_nxt = end_w;
            if (in_item.run_is_null) begin
              null_total_nxt = null_total_r + (end_w - last_end_r);
            end
          end
        end
        default: begin
          cnt_nxt = cnt_r;
        end
      endcase
    end
  end

  // result beat
  always_comb begin
    out_valid_nxt = 1'b0;
    out_item_nxt  = out_item_r;
    if (accept && !go) begin
      out_valid_nxt             = 1'b1;
      out_item_nxt.status       = status_w;
      out_item_nxt.run_index    = '0;
      out_item_nxt.run_null     = 1'b0;
      out_item_nxt.total_length = 32'(last_end_nxt);
      out_item_nxt.null_sum     = 32'(null_total_nxt);
      out_item_nxt.run_count    = 11'(cnt_nxt);
    end else if (state_r == ST_SEARCH && srch.done) begin
      out_valid_nxt             = 1'b1;
      out_item_nxt.status       = STAT_OK;
      out_item_nxt.run_index    = 10'(found_idx);
      out_item_nxt.run_null     = srch.run_null;
      out_item_nxt.total_length = 32'(last_end_r);
      out_item_nxt.null_sum     = 32'(null_total_r);
      out_item_nxt.run_count    = 11'(cnt_r);
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      cnt_r        <= '0;
      last_end_r   <= '0;
      null_total_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      cnt_r        <= cnt_nxt;
      last_end_r   <= last_end_nxt;
      null_total_r <= null_total_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    out_item_r <= out_item_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

### design/reil_chk.sv
module reil_chk #(
  parameter int unsigned MAX_RUNS = reil_pkg::MAX_RUNS_DEF
) (
  input logic                clk,
  input logic                rst_n,
  input logic                start,
  input reil_pkg::reil_in_t  in_item,
  input logic                busy,
  input logic                out_valid,
  input reil_pkg::reil_out_t out_item
);
  import reil_pkg::*;

  // a clear beat leaves an empty table in its result
  a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_item.cmd == CMD_CLEAR |=>
      out_valid && out_item.total_length == 32'd0 && out_item.null_sum == 32'd0 &&
      out_item.run_count == 11'd0)
    else $error("clear did not empty the table");

  // failed beats carry no run
  a_error_no_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.status != STAT_OK |->
      out_item.run_index == 10'd0 && !out_item.run_null)
    else $error("error result carries a run");

  // null runs never exceed the logical length
  a_null_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_item.null_sum <= out_item.total_length)
    else $error("null count above length");

  // table full only at capacity
  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.status == STAT_FULL |-> out_item.run_count == 11'(MAX_RUNS))
    else $error("table full below capacity");

  // only a lookup beat starts a search
  a_busy_lookup: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(busy) |-> $past(start) && $past(in_item.cmd) == CMD_LOOKUP)
    else $error("busy without lookup");

endmodule

bind run_end_index_lookup reil_chk #(.MAX_RUNS(MAX_RUNS)) u_reil_chk (.*);
